[rtl/core/grd_pkg.sv]
// Shared types, constants and helpers of the glyph run decoder.
// Depends on nothing; the front stage, queue, decoder, result stage, top level and bench import it.
`timescale 1ns / 1ps

package grd_pkg;

  localparam int COORD_BITS_DEFAULT = 8;
  localparam int MAX_RESULTS        = 64;
  localparam int COUNT_BITS         = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_BITS       = 3;
  localparam int CFG_DATA_BITS      = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_BG_RUN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FG_RUN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADVANCE  = 3'd6;

  localparam logic [CFG_DATA_BITS-1:0] RST_BG_RUN   = 4'd2;
  localparam logic [CFG_DATA_BITS-1:0] RST_FG_RUN   = 4'd2;
  localparam logic [CFG_DATA_BITS-1:0] RST_WIDTH    = 4'd4;
  localparam logic [CFG_DATA_BITS-1:0] RST_HEIGHT   = 4'd4;
  localparam logic [CFG_DATA_BITS-1:0] RST_OFFSET_X = 4'd3;
  localparam logic [CFG_DATA_BITS-1:0] RST_OFFSET_Y = 4'd3;
  localparam logic [CFG_DATA_BITS-1:0] RST_ADVANCE  = 4'd4;

  localparam logic [1:0] KIND_SEGMENT  = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  localparam logic ITEM_BODY  = 1'b0;
  localparam logic ITEM_START = 1'b1;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] background_run_bits;
    logic [CFG_DATA_BITS-1:0] foreground_run_bits;
    logic [CFG_DATA_BITS-1:0] width_bits;
    logic [CFG_DATA_BITS-1:0] height_bits;
    logic [CFG_DATA_BITS-1:0] offset_x_bits;
    logic [CFG_DATA_BITS-1:0] offset_y_bits;
    logic [CFG_DATA_BITS-1:0] advance_bits;
  } cfg_t;

  typedef struct packed {
    logic       cls;
    logic [7:0] glyph_byte;
    logic [7:0] origin_x;
    logic [7:0] origin_y;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] len;
    logic       colour;
    logic [7:0] adv;
  } record_t;

  typedef struct packed {
    logic    valid;
    logic    is_end;
    record_t rec;
  } event_t;

  function automatic logic [3:0] field_bits(input logic [CFG_DATA_BITS-1:0] c);
    logic [3:0] n;
    n = 4'(c);
    if (n == 4'd0) n = 4'd1;
    if (n > 4'd8) n = 4'd8;
    return n;
  endfunction

  function automatic logic [7:0] offset_signed(input logic [7:0] v, input logic [3:0] n);
    return v - (8'd1 << (n - 4'd1));
  endfunction

endpackage

[rtl/core/grd_in_if.sv]
// Request channel carrying glyph stream bytes with the pen origin.
// Depends on nothing.
`timescale 1ns / 1ps

interface grd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph_byte;
  logic       first_of_glyph;
  logic [7:0] origin_x;
  logic [7:0] origin_y;

  modport source (output valid, glyph_byte, first_of_glyph, origin_x, origin_y,
                  input ready);
  modport sink   (input valid, glyph_byte, first_of_glyph, origin_x, origin_y,
                  output ready);
endinterface

[rtl/core/grd_out_if.sv]
// Result channel carrying decoded segment, done and overflow records.
// Depends on nothing.
`timescale 1ns / 1ps

interface grd_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        record_kind;
  logic [7:0]        seg_x;
  logic [7:0]        seg_y;
  logic [7:0]        seg_length;
  logic              seg_colour;
  logic signed [7:0] advance_width;
  logic              last_result;

  modport source (output valid, record_kind, seg_x, seg_y, seg_length, seg_colour,
                  advance_width, last_result, input ready);
  modport sink   (input valid, record_kind, seg_x, seg_y, seg_length, seg_colour,
                  advance_width, last_result, output ready);
endinterface

[rtl/core/grd_front.sv]
// Front stage: accepts stream requests, tags them as glyph start or body.
// Depends on grd_pkg and grd_in_if.
`timescale 1ns / 1ps

module grd_front (
  input  logic           clk,
  input  logic           rst,
  grd_in_if.sink         glyph,
  output logic           item_valid,
  input  logic           item_ready,
  output grd_pkg::item_t item
);
  import grd_pkg::*;

  logic  held;
  item_t held_item;

  assign glyph.ready = !held || item_ready;
  assign item_valid  = held;
  assign item        = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (glyph.ready) begin
      held <= glyph.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (glyph.valid && glyph.ready) begin
      held_item.cls        <= glyph.first_of_glyph ? ITEM_START : ITEM_BODY;
      held_item.glyph_byte <= glyph.glyph_byte;
      held_item.origin_x   <= glyph.origin_x;
      held_item.origin_y   <= glyph.origin_y;
    end
  end

endmodule

[rtl/core/grd_fifo.sv]
// Two-entry queue between the front stage and the decoder.
// Depends on grd_pkg.
`timescale 1ns / 1ps

module grd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  grd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output grd_pkg::item_t pop_item
);
  import grd_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

[rtl/core/grd_decoder.sv]
// Back end: bit reader, header and run decoder, row splitter of runs.
// Depends on grd_pkg; one field or one row piece per cycle while the result stage accepts events.
`timescale 1ns / 1ps

module grd_decoder #(
  parameter int COORD_BITS = grd_pkg::COORD_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  grd_pkg::cfg_t   cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  grd_pkg::item_t  item,
  output grd_pkg::event_t ev,
  input  logic            ev_ready
);
  import grd_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_W    = 4'd1;
  localparam logic [3:0] PH_H    = 4'd2;
  localparam logic [3:0] PH_XO   = 4'd3;
  localparam logic [3:0] PH_YO   = 4'd4;
  localparam logic [3:0] PH_ADV  = 4'd5;
  localparam logic [3:0] PH_BG   = 4'd6;
  localparam logic [3:0] PH_FG   = 4'd7;
  localparam logic [3:0] PH_CONT = 4'd8;

  logic [15:0]           bit_buffer;
  logic [4:0]            bits_available;
  logic [3:0]            decode_phase;
  logic [7:0]            box_width;
  logic [7:0]            box_height;
  logic [COORD_BITS-1:0] draw_base_x;
  logic [COORD_BITS-1:0] draw_base_y;
  logic [7:0]            column_pos;
  logic [7:0]            row_pos;
  logic [7:0]            advance;
  logic [7:0]            saved_bg_run;
  logic [7:0]            saved_fg_run;
  logic                  loaded;
  logic                  draw_act;
  logic [7:0]            draw_cnt;
  logic                  draw_colour;
  logic                  draw_more;

  logic [3:0]  need;
  logic        have_field;
  logic [7:0]  field_val;
  logic [7:0]  off_val;
  logic        width_pos;
  logic        finish_now;
  logic [7:0]  rem_raw;
  logic [7:0]  rem;
  logic [7:0]  col_eff;
  logic [7:0]  cur;
  logic        start;
  logic        step;

  always_comb begin
    case (decode_phase)
      PH_W:    need = field_bits(cfg.width_bits);
      PH_H:    need = field_bits(cfg.height_bits);
      PH_XO:   need = field_bits(cfg.offset_x_bits);
      PH_YO:   need = field_bits(cfg.offset_y_bits);
      PH_ADV:  need = field_bits(cfg.advance_bits);
      PH_BG:   need = field_bits(cfg.background_run_bits);
      PH_FG:   need = field_bits(cfg.foreground_run_bits);
      PH_CONT: need = 4'd1;
      default: need = 4'd0;
    endcase
  end

  assign have_field = (need != 4'd0) && (bits_available >= 5'(need));
  assign field_val  = 8'(bit_buffer & ((16'd1 << need) - 16'd1));
  assign off_val    = offset_signed(field_val, need);
  assign width_pos  = !box_width[7] && (box_width != 8'd0);
  assign finish_now = have_field &&
                      (((decode_phase == PH_ADV) && !width_pos) ||
                       ((decode_phase == PH_CONT) && !field_val[0] &&
                        ($signed(row_pos) >= $signed(box_height))));

  assign rem_raw = box_width - column_pos;
  assign rem     = (rem_raw == 8'd0) ? box_width : rem_raw;
  assign col_eff = (rem_raw == 8'd0) ? 8'd0 : column_pos;
  assign cur     = (draw_cnt < rem) ? draw_cnt : rem;

  assign item_ready = !loaded;
  assign start      = (item.cls == ITEM_START);
  assign step       = loaded && ev_ready;

  always_comb begin
    ev        = '0;
    ev.valid  = loaded && (draw_act ? (cur != 8'd0) : (!have_field || finish_now));
    ev.is_end = !draw_act && !have_field;
    if (draw_act) begin
      ev.rec.kind   = KIND_SEGMENT;
      ev.rec.x      = 8'(draw_base_x + COORD_BITS'(col_eff));
      ev.rec.y      = 8'(draw_base_y + COORD_BITS'(row_pos));
      ev.rec.len    = cur;
      ev.rec.colour = draw_colour;
    end else if (have_field) begin
      ev.rec.kind = KIND_DONE;
      ev.rec.adv  = (decode_phase == PH_ADV) ? off_val : advance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer     <= '0;
      bits_available <= '0;
      decode_phase   <= PH_IDLE;
      box_width      <= '0;
      box_height     <= '0;
      draw_base_x    <= '0;
      draw_base_y    <= '0;
      column_pos     <= '0;
      row_pos        <= '0;
      advance        <= '0;
      saved_bg_run   <= '0;
      saved_fg_run   <= '0;
      loaded         <= 1'b0;
      draw_act       <= 1'b0;
      draw_cnt       <= '0;
      draw_colour    <= 1'b0;
      draw_more      <= 1'b0;
    end else if (!loaded) begin
      if (item_valid && (start || (decode_phase != PH_IDLE))) begin
        loaded <= 1'b1;
        if (start) begin
          decode_phase   <= PH_W;
          bit_buffer     <= 16'(item.glyph_byte);
          bits_available <= 5'd8;
          draw_base_x    <= COORD_BITS'(item.origin_x);
          draw_base_y    <= COORD_BITS'(item.origin_y);
          column_pos     <= '0;
          row_pos        <= '0;
        end else begin
          bit_buffer     <= bit_buffer | (16'(item.glyph_byte) << bits_available);
          bits_available <= bits_available + 5'd8;
        end
      end
    end else if (step) begin
      if (draw_act) begin
        if (draw_cnt < rem) begin
          column_pos <= col_eff + draw_cnt;
        end else begin
          column_pos <= '0;
          row_pos    <= row_pos + 8'd1;
        end
        if (draw_cnt <= rem) begin
          if (draw_more) begin
            draw_cnt    <= saved_fg_run;
            draw_colour <= 1'b1;
            draw_more   <= 1'b0;
          end else begin
            draw_act <= 1'b0;
          end
        end else begin
          draw_cnt <= draw_cnt - rem;
        end
      end else if (!have_field) begin
        loaded <= 1'b0;
      end else begin
        if (finish_now) begin
          decode_phase   <= PH_IDLE;
          bit_buffer     <= '0;
          bits_available <= '0;
        end else begin
          bit_buffer     <= bit_buffer >> need;
          bits_available <= bits_available - 5'(need);
        end
        case (decode_phase)
          PH_W: begin
            box_width    <= field_val;
            decode_phase <= PH_H;
          end
          PH_H: begin
            box_height   <= field_val;
            decode_phase <= PH_XO;
          end
          PH_XO: begin
            draw_base_x  <= draw_base_x + COORD_BITS'($signed(off_val));
            decode_phase <= PH_YO;
          end
          PH_YO: begin
            draw_base_y  <= draw_base_y - COORD_BITS'($signed(box_height)) -
                            COORD_BITS'($signed(off_val));
            decode_phase <= PH_ADV;
          end
          PH_ADV: begin
            advance <= off_val;
            if (width_pos) begin
              column_pos   <= '0;
              row_pos      <= '0;
              decode_phase <= PH_BG;
            end
          end
          PH_BG: begin
            saved_bg_run <= field_val;
            decode_phase <= PH_FG;
          end
          PH_FG: begin
            saved_fg_run <= field_val;
            draw_act     <= 1'b1;
            draw_cnt     <= saved_bg_run;
            draw_colour  <= 1'b0;
            draw_more    <= 1'b1;
            decode_phase <= PH_CONT;
          end
          PH_CONT: begin
            if (field_val[0]) begin
              draw_act    <= 1'b1;
              draw_cnt    <= saved_bg_run;
              draw_colour <= 1'b0;
              draw_more   <= 1'b1;
            end else if (!finish_now) begin
              decode_phase <= PH_BG;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/grd_result.sv]
// Result stage: holds one record back to mark the last of a request,
// folds excess records into an overflow record. Depends on grd_pkg, grd_out_if.
`timescale 1ns / 1ps

module grd_result (
  input  logic            clk,
  input  logic            rst,
  input  grd_pkg::event_t ev,
  output logic            ev_ready,
  grd_out_if.source       records
);
  import grd_pkg::*;

  logic                  pend_valid;
  record_t               pend_rec;
  logic [COUNT_BITS-1:0] count;
  logic                  over;
  logic                  out_valid;
  record_t               out_rec;
  logic                  out_last;
  logic                  take;
  logic                  push;
  record_t               overflow_rec;

  assign ev_ready = !out_valid || records.ready;
  assign take     = ev.valid && ev_ready;
  assign push     = take && pend_valid &&
                    (ev.is_end || (!over && (count != COUNT_BITS'(MAX_RESULTS))));

  always_comb begin
    overflow_rec      = '0;
    overflow_rec.kind = KIND_OVERFLOW;
  end

  assign records.valid         = out_valid;
  assign records.record_kind   = out_rec.kind;
  assign records.seg_x         = out_rec.x;
  assign records.seg_y         = out_rec.y;
  assign records.seg_length    = out_rec.len;
  assign records.seg_colour    = out_rec.colour;
  assign records.advance_width = $signed(out_rec.adv);
  assign records.last_result   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      count      <= '0;
      over       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= (out_valid && !records.ready) || push;
      if (take) begin
        if (ev.is_end) begin
          pend_valid <= 1'b0;
          count      <= '0;
          over       <= 1'b0;
        end else if (!over) begin
          if (count == COUNT_BITS'(MAX_RESULTS)) begin
            over <= 1'b1;
          end else begin
            pend_valid <= 1'b1;
            count      <= count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_rec  <= pend_rec;
      out_last <= ev.is_end;
    end
    if (take && !ev.is_end && !over) begin
      if (count == COUNT_BITS'(MAX_RESULTS)) begin
        pend_rec <= overflow_rec;
      end else begin
        pend_rec <= ev.rec;
      end
    end
  end

endmodule

[rtl/core/glyph_rle_run_decoder.sv]
// Top level of the run-length glyph decoder: configuration registers,
// front stage, queue, decoder and result stage. Depends on grd_pkg and both interfaces.
//
//   channel   direction  payload
//   glyph     request    glyph_byte, first_of_glyph, origin_x, origin_y
//   records   result     record_kind, seg_x, seg_y, seg_length, seg_colour,
//                        advance_width, last_result
//   cfg_*     write      cfg_index selects one of seven field width registers
//
// The decoder loads each byte, decodes its fields and cuts each run into row pieces (an
// empty run still takes a step), then closes the request.
// Results trail by one record: the last one is held until the request closes.
// Synchronous reset clears control state and loads the register defaults.
// A stalled result port holds the decoder; the input register and two-entry queue
// keep taking bytes meanwhile until they are full.
`timescale 1ns / 1ps

module glyph_rle_run_decoder #(
  parameter int COORD_BITS = grd_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  grd_in_if.sink                             glyph,
  grd_out_if.source                          records,
  input  logic                               cfg_write,
  input  logic [grd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [grd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import grd_pkg::*;

  cfg_t   cfg;
  logic   front_valid;
  logic   front_ready;
  item_t  front_item;
  logic   queue_valid;
  logic   queue_ready;
  item_t  queue_item;
  event_t ev;
  logic   ev_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.background_run_bits <= RST_BG_RUN;
      cfg.foreground_run_bits <= RST_FG_RUN;
      cfg.width_bits          <= RST_WIDTH;
      cfg.height_bits         <= RST_HEIGHT;
      cfg.offset_x_bits       <= RST_OFFSET_X;
      cfg.offset_y_bits       <= RST_OFFSET_Y;
      cfg.advance_bits        <= RST_ADVANCE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BG_RUN:   cfg.background_run_bits <= cfg_data;
        REG_FG_RUN:   cfg.foreground_run_bits <= cfg_data;
        REG_WIDTH:    cfg.width_bits          <= cfg_data;
        REG_HEIGHT:   cfg.height_bits         <= cfg_data;
        REG_OFFSET_X: cfg.offset_x_bits       <= cfg_data;
        REG_OFFSET_Y: cfg.offset_y_bits       <= cfg_data;
        REG_ADVANCE:  cfg.advance_bits        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  grd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .glyph      (glyph),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  grd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  grd_decoder #(
    .COORD_BITS (COORD_BITS)
  ) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .ev         (ev),
    .ev_ready   (ev_ready)
  );

  grd_result u_result (
    .clk      (clk),
    .rst      (rst),
    .ev       (ev),
    .ev_ready (ev_ready),
    .records  (records)
  );

  a_overflow_last: assert property (@(posedge clk) disable iff (rst)
    (records.valid && (records.record_kind == KIND_OVERFLOW)) |-> records.last_result)
    else $error("overflow record not marked last");

  a_segment_length: assert property (@(posedge clk) disable iff (rst)
    (records.valid && (records.record_kind == KIND_SEGMENT)) |->
    (records.seg_length != 8'd0))
    else $error("segment record with zero length");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (records.valid && (records.record_kind == KIND_DONE)) |->
    ((records.seg_length == 8'd0) && !records.seg_colour))
    else $error("done record carries segment fields");

endmodule

[tb/glyph_rle_run_decoder_tb.sv]
// Self-checking bench for glyph_rle_run_decoder: directed and random glyph byte streams
// under several field-width settings, each record checked against a decode model kept here.
// Depends on grd_pkg, grd_in_if, grd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module glyph_rle_run_decoder_tb;
  import grd_pkg::*;

  localparam int PHASE_ITEMS   = 50;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT   = 100000;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_WIDTH   = 4'd1;
  localparam logic [3:0] ST_HEIGHT  = 4'd2;
  localparam logic [3:0] ST_XOFF    = 4'd3;
  localparam logic [3:0] ST_YOFF    = 4'd4;
  localparam logic [3:0] ST_ADVANCE = 4'd5;
  localparam logic [3:0] ST_BG_RUN  = 4'd6;
  localparam logic [3:0] ST_FG_RUN  = 4'd7;
  localparam logic [3:0] ST_REPEAT  = 4'd8;

  typedef struct packed {
    record_t rec;
    logic    last;
  } awaited_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;

  grd_in_if  glyph_ch ();
  grd_out_if record_ch ();

  glyph_rle_run_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .glyph     (glyph_ch),
    .records   (record_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // decode model state
  logic [3:0]  field_cfg [7];
  logic [15:0] bit_buf = '0;
  int unsigned bit_cnt = 0;
  logic [3:0]  dec_state = ST_IDLE;
  logic [7:0]  g_width = '0, g_height = '0, base_x = '0, base_y = '0;
  logic [7:0]  col = '0, row = '0, adv = '0, bg_run = '0, fg_run = '0;
  record_t     step_records [$];
  bit          step_over;

  awaited_t    awaited [$];
  item_t       byte_queue [$];
  item_t       shown_item;
  bit          stream_bits [$];

  int unsigned src_mode = 0, snk_mode = 0, gap_left = 0, hold_cnt = 0;
  int unsigned fail_count = 0, sent_count = 0, counted_items = 0, loose_bytes = 0;
  int unsigned records_checked = 0, glyph_ends = 0, overflows = 0, settings_used = 0;

  function automatic int unsigned clamp_bits(input logic [3:0] c);
    if (c == 4'd0) return 1;
    if (c > 4'd8) return 8;
    return c;
  endfunction

  function automatic int unsigned draw_pause(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  function automatic void put_record(input logic [1:0] kind, input logic [7:0] x, y, len,
                                     input logic colour, input logic [7:0] advance);
    record_t r;
    if (step_records.size() >= MAX_RESULTS) begin
      step_over = 1'b1;
      return;
    end
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.len = len;
    r.colour = colour;
    r.adv = advance;
    step_records.push_back(r);
  endfunction

  // cut a run into row pieces
  task automatic lay_run(input logic [7:0] len, input logic colour);
    int unsigned cnt, rem, cur;
    logic [7:0] span;
    cnt = len;
    while (1) begin
      span = g_width - col;
      if (span == 8'd0) begin
        col = '0;
        span = g_width;
      end
      rem = span;
      cur = (cnt < rem) ? cnt : rem;
      if (cur > 0) put_record(KIND_SEGMENT, base_x + col, base_y + row, 8'(cur), colour, '0);
      if (cnt < rem) break;
      cnt -= rem;
      col = '0;
      row = row + 8'd1;
    end
    col = col + 8'(cnt);
  endtask

  task automatic close_glyph();
    put_record(KIND_DONE, '0, '0, '0, 1'b0, adv);
    dec_state = ST_IDLE;
    bit_buf = '0;
    bit_cnt = 0;
  endtask

  task automatic decode_byte(input item_t it);
    int unsigned n;
    logic [7:0] v, s;
    record_t ovf;
    awaited_t a;
    step_records.delete();
    step_over = 1'b0;
    if (it.cls == ITEM_START) begin
      dec_state = ST_WIDTH;
      bit_buf = '0;
      bit_cnt = 0;
      base_x = it.origin_x;
      base_y = it.origin_y;
      col = '0;
      row = '0;
    end
    if (dec_state == ST_IDLE) return;
    bit_buf = bit_buf | (16'(it.glyph_byte) << bit_cnt);
    bit_cnt += 8;
    while (dec_state != ST_IDLE) begin
      case (dec_state)
        ST_WIDTH:   n = clamp_bits(field_cfg[REG_WIDTH]);
        ST_HEIGHT:  n = clamp_bits(field_cfg[REG_HEIGHT]);
        ST_XOFF:    n = clamp_bits(field_cfg[REG_OFFSET_X]);
        ST_YOFF:    n = clamp_bits(field_cfg[REG_OFFSET_Y]);
        ST_ADVANCE: n = clamp_bits(field_cfg[REG_ADVANCE]);
        ST_BG_RUN:  n = clamp_bits(field_cfg[REG_BG_RUN]);
        ST_FG_RUN:  n = clamp_bits(field_cfg[REG_FG_RUN]);
        default:    n = 1;
      endcase
      if (bit_cnt < n) break;
      v = 8'(bit_buf & ((16'd1 << n) - 16'd1));
      bit_buf = bit_buf >> n;
      bit_cnt -= n;
      s = v - (8'd1 << (n - 1));
      case (dec_state)
        ST_WIDTH: begin
          g_width = v;
          dec_state = ST_HEIGHT;
        end
        ST_HEIGHT: begin
          g_height = v;
          dec_state = ST_XOFF;
        end
        ST_XOFF: begin
          base_x = base_x + s;
          dec_state = ST_YOFF;
        end
        ST_YOFF: begin
          base_y = base_y - g_height - s;
          dec_state = ST_ADVANCE;
        end
        ST_ADVANCE: begin
          adv = s;
          if ($signed(g_width) > 0) begin
            col = '0;
            row = '0;
            dec_state = ST_BG_RUN;
          end else begin
            close_glyph();
          end
        end
        ST_BG_RUN: begin
          bg_run = v;
          dec_state = ST_FG_RUN;
        end
        ST_FG_RUN: begin
          fg_run = v;
          lay_run(bg_run, 1'b0);
          lay_run(fg_run, 1'b1);
          dec_state = ST_REPEAT;
        end
        default: begin
          if (v[0]) begin
            lay_run(bg_run, 1'b0);
            lay_run(fg_run, 1'b1);
          end else if ($signed(row) >= $signed(g_height)) begin
            close_glyph();
          end else begin
            dec_state = ST_BG_RUN;
          end
        end
      endcase
    end
    if (step_over) begin
      ovf = '0;
      ovf.kind = KIND_OVERFLOW;
      step_records[MAX_RESULTS-1] = ovf;
    end
    foreach (step_records[i]) begin
      a.rec = step_records[i];
      a.last = (i == step_records.size() - 1);
      awaited.push_back(a);
    end
  endtask

  // request side
  always @(posedge clk) begin : source_side
    if (rst) begin
      glyph_ch.valid <= 1'b0;
      glyph_ch.glyph_byte <= '0;
      glyph_ch.first_of_glyph <= ITEM_BODY;
      glyph_ch.origin_x <= '0;
      glyph_ch.origin_y <= '0;
      gap_left <= 0;
    end else begin
      if (glyph_ch.valid && glyph_ch.ready) begin
        decode_byte(shown_item);
        sent_count++;
      end
      if (!glyph_ch.valid || glyph_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          glyph_ch.valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          shown_item = byte_queue.pop_front();
          glyph_ch.glyph_byte <= shown_item.glyph_byte;
          glyph_ch.first_of_glyph <= shown_item.cls;
          glyph_ch.origin_x <= shown_item.origin_x;
          glyph_ch.origin_y <= shown_item.origin_y;
          glyph_ch.valid <= 1'b1;
          gap_left <= draw_pause(src_mode);
        end else begin
          glyph_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result side
  always @(posedge clk) begin : sink_side
    awaited_t want;
    int unsigned pause;
    if (rst) begin
      record_ch.ready <= 1'b0;
      hold_cnt <= 0;
    end else if (record_ch.valid && record_ch.ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected record kind %0d x %0d y %0d len %0d colour %0d adv %0d last %0d",
                 $time, record_ch.record_kind, record_ch.seg_x, record_ch.seg_y,
                 record_ch.seg_length, record_ch.seg_colour, record_ch.advance_width,
                 record_ch.last_result);
        fail_count++;
      end else begin
        want = awaited.pop_front();
        compare_field("record_kind", want.rec.kind, record_ch.record_kind);
        compare_field("seg_x", want.rec.x, record_ch.seg_x);
        compare_field("seg_y", want.rec.y, record_ch.seg_y);
        compare_field("seg_length", want.rec.len, record_ch.seg_length);
        compare_field("seg_colour", want.rec.colour, record_ch.seg_colour);
        compare_field("advance_width", want.rec.adv, record_ch.advance_width);
        compare_field("last_result", want.last, record_ch.last_result);
        records_checked++;
        if (want.rec.kind == KIND_DONE) glyph_ends++;
        if (want.rec.kind == KIND_OVERFLOW) overflows++;
      end
      pause = draw_pause(snk_mode);
      hold_cnt <= pause;
      record_ch.ready <= (pause == 0);
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      record_ch.ready <= (hold_cnt == 1);
    end else begin
      record_ch.ready <= 1'b1;
    end
  end

  task automatic set_fields(input logic [3:0] bg, fg, wd, ht, ox, oy, av);
    logic [2:0] idx [7];
    logic [3:0] vals [7];
    idx = '{REG_BG_RUN, REG_FG_RUN, REG_WIDTH, REG_HEIGHT, REG_OFFSET_X, REG_OFFSET_Y,
            REG_ADVANCE};
    vals = '{bg, fg, wd, ht, ox, oy, av};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      field_cfg[idx[i]] = vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [3:0] pick_setting();
    return ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
  endfunction

  function automatic void push_request(input logic [7:0] b, input logic cls, input bit counted);
    item_t it;
    it.cls = cls;
    it.glyph_byte = b;
    it.origin_x = 8'($urandom);
    it.origin_y = 8'($urandom);
    byte_queue.push_back(it);
    if (counted) counted_items++;
    else loose_bytes++;
  endfunction

  function automatic void put_bits(input int unsigned value, input int unsigned n);
    for (int i = 0; i < n; i++) stream_bits.push_back(value[i]);
  endfunction

  function automatic int unsigned pick_run(input int unsigned n, input logic [7:0] w8,
                                           input bit longest);
    int unsigned top, lim;
    top = (1 << n) - 1;
    if (longest) return top;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, top);
    lim = 2 * w8;
    return $urandom_range(0, (top < lim) ? top : lim);
  endfunction

  // assemble one glyph as a bit stream, then split it into requests
  task automatic build_glyph(input int unsigned w, h, input bit cut, input bit longest);
    int unsigned nw, nh, nb, nf, pairs, total, bgv, fgv, nbytes;
    logic [7:0] w8, h8, row8, b;
    nw = clamp_bits(field_cfg[REG_WIDTH]);
    nh = clamp_bits(field_cfg[REG_HEIGHT]);
    nb = clamp_bits(field_cfg[REG_BG_RUN]);
    nf = clamp_bits(field_cfg[REG_FG_RUN]);
    w8 = 8'(w & ((1 << nw) - 1));
    h8 = 8'(h & ((1 << nh) - 1));
    stream_bits.delete();
    put_bits(w8, nw);
    put_bits(h8, nh);
    put_bits($urandom, clamp_bits(field_cfg[REG_OFFSET_X]));
    put_bits($urandom, clamp_bits(field_cfg[REG_OFFSET_Y]));
    put_bits($urandom, clamp_bits(field_cfg[REG_ADVANCE]));
    if ($signed(w8) > 0) begin
      total = 0;
      pairs = 0;
      do begin
        bgv = pick_run(nb, w8, longest && pairs == 0);
        fgv = pick_run(nf, w8, longest && pairs == 0);
        put_bits(bgv, nb);
        put_bits(fgv, nf);
        total += bgv + fgv;
        pairs++;
        while ($urandom_range(0, 3) == 0) begin
          put_bits(1, 1);
          total += bgv + fgv;
        end
        put_bits(0, 1);
        row8 = 8'(total / w8);
      end while ($signed(row8) < $signed(h8) && pairs < 120);
    end
    while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(0, 1));
    nbytes = stream_bits.size() / 8;
    if (cut && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
    for (int i = 0; i < nbytes; i++) begin
      for (int k = 0; k < 8; k++) b[k] = stream_bits[8*i+k];
      push_request(b, (i == 0) ? ITEM_START : ITEM_BODY, 1'b1);
    end
  endtask

  task automatic random_phase();
    int unsigned target, pick, nw, nh, w, h, extra;
    src_mode = $urandom_range(0, 2);
    snk_mode = $urandom_range(0, 2);
    target = counted_items + PHASE_ITEMS;
    while (counted_items < target) begin
      nw = clamp_bits(field_cfg[REG_WIDTH]);
      nh = clamp_bits(field_cfg[REG_HEIGHT]);
      if ($urandom_range(0, 9) == 0) w = 0;
      else if (nw == 8 && $urandom_range(0, 9) == 0) w = $urandom_range(128, 255);
      else w = $urandom_range(1, (((1 << nw) - 1) < 12) ? (1 << nw) - 1 : 12);
      if (nh == 8 && $urandom_range(0, 9) == 0) h = $urandom_range(128, 255);
      else h = $urandom_range(0, (((1 << nh) - 1) < 6) ? (1 << nh) - 1 : 6);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_glyph(w, h, 1'b0, $urandom_range(0, 15) == 0);
      end else if (pick == 7) begin
        build_glyph(w, h, 1'b1, 1'b0);
      end else if (pick == 8) begin
        push_request(8'($urandom), ITEM_BODY, 1'b0);
      end else begin
        extra = $urandom_range(0, 3);
        push_request(8'($urandom), ITEM_START, 1'b1);
        repeat (extra) push_request(8'($urandom), ITEM_BODY, 1'b1);
      end
    end
  endtask

  // let every request land and every record leave, then allow for silent work
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (byte_queue.size() != 0 || glyph_ch.valid) @(posedge clk);
    while (awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_write <= 1'b0;
    cfg_index <= REG_BG_RUN;
    cfg_data <= RST_BG_RUN;
    field_cfg[REG_BG_RUN] = RST_BG_RUN;
    field_cfg[REG_FG_RUN] = RST_FG_RUN;
    field_cfg[REG_WIDTH] = RST_WIDTH;
    field_cfg[REG_HEIGHT] = RST_HEIGHT;
    field_cfg[REG_OFFSET_X] = RST_OFFSET_X;
    field_cfg[REG_OFFSET_Y] = RST_OFFSET_Y;
    field_cfg[REG_ADVANCE] = RST_ADVANCE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset widths: stray byte, plain glyph, zero width, restart mid glyph
    src_mode = 1;
    snk_mode = 2;
    push_request(8'($urandom), ITEM_BODY, 1'b0);
    build_glyph(3, 2, 1'b0, 1'b0);
    build_glyph(0, 3, 1'b0, 1'b0);
    build_glyph(5, 3, 1'b1, 1'b0);
    build_glyph(2, 1, 1'b0, 1'b0);
    drain();

    // widest fields: result overflow, negative width
    set_fields(4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8);
    build_glyph(1, 1, 1'b0, 1'b1);
    build_glyph(200, 1, 1'b0, 1'b0);
    random_phase();
    drain();

    set_fields(4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
    random_phase();
    drain();

    set_fields(4'd0, 4'd15, 4'd15, 4'd0, 4'd9, 4'd12, 4'd0);
    random_phase();
    drain();

    repeat (4) begin
      set_fields(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                 pick_setting(), pick_setting(), pick_setting());
      random_phase();
      drain();
    end

    if (awaited.size() != 0) begin
      $display("%0t: %0d records never arrived, first kind %0d x %0d y %0d len %0d",
               $time, awaited.size(), awaited[0].rec.kind, awaited[0].rec.x,
               awaited[0].rec.y, awaited[0].rec.len);
      fail_count++;
    end
    $display("Sent %0d requests (%0d stray body bytes among them) under %0d width settings",
             sent_count, loose_bytes, settings_used + 1);
    $display("Checked %0d records: %0d glyph ends, %0d overflow flags, %0d mismatches",
             records_checked, glyph_ends, overflows, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
